// ----- rtl/core/swsort_pkg.sv -----
// Shared types and constants for the sliding window sorter.
`timescale 1ns / 1ps

package swsort_pkg;

  localparam int DATA_W         = 32;
  localparam int RANK_W         = 3;
  localparam int WINDOW_LEN_DEF = 8;

  localparam logic signed [DATA_W-1:0] EMPTY_MARK = {DATA_W{1'b1}};

  // Per-cell comparison results handed to the neighbouring cells.
  typedef struct packed {
    logic le_del;
    logic le_new;
  } swsort_flags_t;

endpackage

// ----- rtl/core/swsort_cell.sv -----
// One cell of the sorted row: holds one ordered value, updates or rotates.
`timescale 1ns / 1ps

module swsort_cell (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     upd,
  input  logic                                     rot,
  input  logic signed [swsort_pkg::DATA_W-1:0]     new_val,
  input  logic signed [swsort_pkg::DATA_W-1:0]     del_val,
  input  logic signed [swsort_pkg::DATA_W-1:0]     prev_val,
  input  logic signed [swsort_pkg::DATA_W-1:0]     next_val,
  input  swsort_pkg::swsort_flags_t                prev_flags,
  input  swsort_pkg::swsort_flags_t                next_flags,
  output logic signed [swsort_pkg::DATA_W-1:0]     val,
  output swsort_pkg::swsort_flags_t                flags
);

  logic signed [swsort_pkg::DATA_W-1:0] val_r;
  logic signed [swsort_pkg::DATA_W-1:0] val_nxt;
  logic signed [swsort_pkg::DATA_W-1:0] rem_self;
  logic signed [swsort_pkg::DATA_W-1:0] rem_prev;
  logic signed [swsort_pkg::DATA_W-1:0] ins_val;
  logic                                 rem_self_le;
  logic                                 rem_prev_le;

  assign val          = val_r;
  assign flags.le_del = (val_r <= del_val);
  assign flags.le_new = (val_r <= new_val);

  // The row with the departing value removed, as seen at this place and the one before.
  assign rem_self    = next_flags.le_del ? val_r : next_val;
  assign rem_prev    = flags.le_del ? prev_val : val_r;
  assign rem_self_le = next_flags.le_del ? flags.le_new : next_flags.le_new;
  assign rem_prev_le = flags.le_del ? prev_flags.le_new : flags.le_new;

  // The new value then goes in after every remaining value not above it.
  assign ins_val = rem_self_le ? rem_self : (rem_prev_le ? new_val : rem_prev);

  always_comb begin
    if (rot) begin
      val_nxt = next_val;
    end else if (upd) begin
      val_nxt = ins_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= swsort_pkg::EMPTY_MARK;
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

// ----- rtl/core/sliding_window_sorter.sv -----
// Top level of the sliding window sorter: sample window, sorted cell row and result sequencing.
// In the cycle after acceptance the row of sorted cells has already dropped the oldest sample
// and taken in the new one, and the WINDOW_LEN result beats then leave from the first cell, one
// per cycle unless the result side stalls, as the row rotates one place per beat and comes back
// to order after the last. A new sample is taken only once the last beat of the previous one has
// gone. Results come out in ascending signed order with rank, a mark on the last beat and a flag
// that is low while any window entry holds -1; the window starts out as all -1.
`timescale 1ns / 1ps

module sliding_window_sorter #(
  parameter int WINDOW_LEN = swsort_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swsort_pkg::DATA_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swsort_pkg::DATA_W-1:0] out_sorted_value,
  output logic        [swsort_pkg::RANK_W-1:0] out_rank,
  output logic                                 out_last_of_run,
  output logic                                 out_window_full
);

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                                state_r;
  state_t                                state_nxt;
  logic signed [swsort_pkg::DATA_W-1:0]  win_r [WINDOW_LEN];
  logic        [CNT_W-1:0]               empty_cnt_r;
  logic        [CNT_W-1:0]               empty_cnt_nxt;
  logic                                  full_r;
  logic        [IDX_W-1:0]               beat_r;
  logic        [IDX_W-1:0]               beat_nxt;
  logic        [swsort_pkg::RANK_W-1:0]  rank_r;
  logic        [swsort_pkg::RANK_W-1:0]  rank_nxt;
  logic                                  take_in;
  logic                                  take_out;
  logic                                  last_beat;
  logic signed [swsort_pkg::DATA_W-1:0]  oldest;
  logic                                  new_empty;
  logic                                  old_empty;

  logic signed [swsort_pkg::DATA_W-1:0]  cell_val   [WINDOW_LEN];
  swsort_pkg::swsort_flags_t             cell_flags [WINDOW_LEN];

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign take_in   = in_valid && in_ready;
  assign take_out  = out_valid && out_ready;
  assign last_beat = (beat_r == IDX_W'(WINDOW_LEN - 1));
  assign oldest    = win_r[WINDOW_LEN-1];
  assign new_empty = (in_sample == swsort_pkg::EMPTY_MARK);
  assign old_empty = (oldest == swsort_pkg::EMPTY_MARK);

  assign out_sorted_value = cell_val[0];
  assign out_rank         = rank_r;
  assign out_last_of_run  = last_beat;
  assign out_window_full  = full_r;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
      logic signed [swsort_pkg::DATA_W-1:0] prev_val;
      logic signed [swsort_pkg::DATA_W-1:0] next_val;
      swsort_pkg::swsort_flags_t            prev_flags;
      swsort_pkg::swsort_flags_t            next_flags;

      if (gi == 0) begin : g_first
        assign prev_val   = cell_val[WINDOW_LEN-1];
        assign prev_flags = '{le_del: 1'b1, le_new: 1'b1};
      end else begin : g_mid_prev
        assign prev_val   = cell_val[gi-1];
        assign prev_flags = cell_flags[gi-1];
      end

      if (gi == WINDOW_LEN - 1) begin : g_last
        assign next_val   = cell_val[0];
        assign next_flags = '{le_del: 1'b0, le_new: 1'b0};
      end else begin : g_mid_next
        assign next_val   = cell_val[gi+1];
        assign next_flags = cell_flags[gi+1];
      end

      swsort_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (take_in),
        .rot        (take_out),
        .new_val    (in_sample),
        .del_val    (oldest),
        .prev_val   (prev_val),
        .next_val   (next_val),
        .prev_flags (prev_flags),
        .next_flags (next_flags),
        .val        (cell_val[gi]),
        .flags      (cell_flags[gi])
      );
    end
  endgenerate

  always_comb begin
    empty_cnt_nxt = empty_cnt_r;
    case ({new_empty, old_empty})
      2'b10:   empty_cnt_nxt = empty_cnt_r + CNT_W'(1);
      2'b01:   empty_cnt_nxt = empty_cnt_r - CNT_W'(1);
      default: empty_cnt_nxt = empty_cnt_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    beat_nxt  = beat_r;
    rank_nxt  = rank_r;
    case (state_r)
      ST_IDLE: begin
        if (take_in) begin
          state_nxt = ST_EMIT;
          beat_nxt  = '0;
          rank_nxt  = '0;
        end
      end
      ST_EMIT: begin
        if (take_out) begin
          beat_nxt = beat_r + IDX_W'(1);
          rank_nxt = rank_r + swsort_pkg::RANK_W'(1);
          if (last_beat) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      beat_r      <= '0;
      rank_r      <= '0;
      empty_cnt_r <= CNT_W'(WINDOW_LEN);
      full_r      <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= swsort_pkg::EMPTY_MARK;
      end
    end else begin
      state_r <= state_nxt;
      beat_r  <= beat_nxt;
      rank_r  <= rank_nxt;
      if (take_in) begin
        empty_cnt_r <= empty_cnt_nxt;
        full_r      <= (empty_cnt_nxt == '0);
        win_r[0]    <= in_sample;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          win_r[i] <= win_r[i-1];
        end
      end
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result sides open together");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (out_valid && out_rank == '0))
    else $error("run did not start at rank zero");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_of_run) |=> in_ready)
    else $error("block not ready after last beat");

  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=>
      (out_sorted_value >= $past(out_sorted_value)))
    else $error("results not in ascending order");

  a_full_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> $stable(out_window_full))
    else $error("full flag changed within a run");

endmodule

// ----- test/sliding_window_sorter_tb.sv -----
// Testbench for the sliding window sorter: random handshake traffic checked against a window model.
`timescale 1ns / 1ps

module sliding_window_sorter_tb;

  localparam int WINDOW_LEN   = swsort_pkg::WINDOW_LEN_DEF;
  localparam int RANDOM_ITEMS = 330;
  localparam int TAIL_ITEMS   = 40;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 3 * WINDOW_LEN;

  typedef struct {
    logic signed [swsort_pkg::DATA_W-1:0] value;
    logic        [swsort_pkg::RANK_W-1:0] rank;
    logic                                 last;
    logic                                 full;
  } sorted_beat_t;

  logic                                 clk       = 1'b0;
  logic                                 rst_n     = 1'b0;
  logic                                 in_valid  = 1'b0;
  logic                                 in_ready;
  logic signed [swsort_pkg::DATA_W-1:0] in_sample = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [swsort_pkg::DATA_W-1:0] out_sorted_value;
  logic        [swsort_pkg::RANK_W-1:0] out_rank;
  logic                                 out_last_of_run;
  logic                                 out_window_full;

  logic signed [swsort_pkg::DATA_W-1:0] sample_q [$];
  sorted_beat_t                         sorted_beats_q [$];
  logic signed [swsort_pkg::DATA_W-1:0] window_q [WINDOW_LEN];
  int                                   in_gap     = 0;
  int                                   out_gap    = 0;
  int                                   idle_count = 0;
  int                                   errors     = 0;

  sliding_window_sorter #(
    .WINDOW_LEN(WINDOW_LEN)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_rank         (out_rank),
    .out_last_of_run  (out_last_of_run),
    .out_window_full  (out_window_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic shift_and_sort(input logic signed [swsort_pkg::DATA_W-1:0] sample);
    logic signed [swsort_pkg::DATA_W-1:0] ordered [WINDOW_LEN];
    logic signed [swsort_pkg::DATA_W-1:0] v;
    logic                                 full;
    int                                   j;
    sorted_beat_t                         beat;
    for (int i = WINDOW_LEN - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = sample;
    full = 1'b1;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      if (window_q[i] == swsort_pkg::EMPTY_MARK) full = 1'b0;
    end
    for (int i = 0; i < WINDOW_LEN; i++) begin
      v = window_q[i];
      j = i;
      while (j > 0 && v < ordered[j-1]) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = v;
    end
    for (int i = 0; i < WINDOW_LEN; i++) begin
      beat.value = ordered[i];
      beat.rank  = swsort_pkg::RANK_W'(i);
      beat.last  = (i == WINDOW_LEN - 1);
      beat.full  = full;
      sorted_beats_q.push_back(beat);
    end
  endtask

  // Sample driver: holds each beat until it is taken, then may pause for a burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        sample_q.delete(0);
        if (sample_q.size() >= TAIL_ITEMS && $urandom_range(0, 3) == 0)
          in_gap = $urandom_range(1, 16);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= sample_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (sample_q.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0)
        out_gap = $urandom_range(1, 16);
    end
  end

  always @(posedge clk) begin
    sorted_beat_t exp_beat;
    if (rst_n) begin
      if (in_valid && in_ready) shift_and_sort(in_sample);
      if (out_valid && out_ready) begin
        if (sorted_beats_q.size() == 0) begin
          $error("unexpected result beat: sorted_value %0d rank %0d", out_sorted_value,
                 out_rank);
          errors++;
        end else begin
          exp_beat = sorted_beats_q.pop_front();
          if (out_sorted_value !== exp_beat.value) begin
            $error("sorted_value: expected %0d, got %0d", exp_beat.value, out_sorted_value);
            errors++;
          end
          if (out_rank !== exp_beat.rank) begin
            $error("rank: expected %0d, got %0d", exp_beat.rank, out_rank);
            errors++;
          end
          if (out_last_of_run !== exp_beat.last) begin
            $error("last_of_run: expected %0b, got %0b", exp_beat.last, out_last_of_run);
            errors++;
          end
          if (out_window_full !== exp_beat.full) begin
            $error("window_full: expected %0b, got %0b", exp_beat.full, out_window_full);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
        $display("sliding_window_sorter_tb NOT OK");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  initial begin
    logic signed [swsort_pkg::DATA_W-1:0] s;
    for (int i = 0; i < WINDOW_LEN; i++) window_q[i] = swsort_pkg::EMPTY_MARK;
    // A -1 sample, the extremes, repeated values and alternating bit patterns, then a
    // second -1 once the window has filled.
    sample_q = '{-32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 32'sd1, -32'sd2,
                 32'sd5, 32'sd5, 32'sd5, 32'sh55555555, 32'shAAAAAAAA, -32'sd1,
                 32'sh7FFFFFFF, 32'sh80000000, -32'sd3, 32'sh7FFFFFFF, 32'sh80000000,
                 32'sd0, 32'sd12345, -32'sd12345};
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0: s = -32'sd1;
        1: begin
          case ($urandom_range(0, 2))
            0:       s = 32'sh7FFFFFFF;
            1:       s = 32'sh80000000;
            default: s = 32'sd0;
          endcase
        end
        2, 3, 4: s = int'($urandom_range(0, 8)) - 4;
        default: s = $urandom;
      endcase
      sample_q.push_back(s);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (sample_q.size() != 0 || sorted_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && sorted_beats_q.size() == 0) begin
      $display("sliding_window_sorter_tb OK");
    end else begin
      $display("sliding_window_sorter_tb NOT OK");
    end
    $finish;
  end

endmodule
